>>> rtl/core/jcand_pkg.sv
// shared types, codes and rank helper for the join candidate table
package jcand_pkg;

    // observation word as it enters the block
    typedef struct packed {
        logic [31:0]        org_key;
        logic [31:0]        site_key;
        logic [31:0]        network_low;
        logic [47:0]        relay_mac;
        logic [63:0]        proxy_node;
        logic [7:0]         radio_channel;
        logic signed [7:0]  signal_strength;
        logic [7:0]         hop_count;
        logic               authority_ok;
        logic               proxy_loaded;
        logic [63:0]        now_ms;
    } t_obs;

    // result word
    typedef struct packed {
        logic [1:0] outcome;
        logic [2:0] record_slot;
    } t_res;

    // queue entry between front and back
    typedef struct packed {
        t_obs obs;
        logic rej;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_SLOT,
        ST_FINAL,
        ST_EMIT
    } t_state;

    localparam logic [1:0] OUTC_UPDATED  = 2'd0;
    localparam logic [1:0] OUTC_INSERTED = 2'd1;
    localparam logic [1:0] OUTC_EVICTED  = 2'd2;
    localparam logic [1:0] OUTC_REJECTED = 2'd3;

    localparam logic [7:0]  CHANNEL_MAX   = 8'd14;
    localparam logic [7:0]  GROUP_BIT     = 8'h01;
    localparam logic [31:0] FRESH_DEFAULT = 32'd30000;

    // a ranks strictly better than b: fewer hops, then stronger, then lower mac
    function automatic logic ranks_better(
        input logic [7:0]        ha,
        input logic signed [7:0] sa,
        input logic [47:0]       ma,
        input logic [7:0]        hb,
        input logic signed [7:0] sb,
        input logic [47:0]       mb
    );
        logic res;
        if (ha != hb) begin
            res = ha < hb;
        end else if (sa != sb) begin
            res = sa > sb;
        end else begin
            res = ma < mb;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/jcand_front.sv
// front end: clock check and observation validation
module jcand_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  jcand_pkg::t_obs   i_obs,
    output jcand_pkg::t_job   o_job,
    output logic              o_lost
);

    logic [63:0] r_last;
    logic        r_lost;
    logic        w_clk_good;
    logic        w_bad_key;
    logic        w_bad_proxy;

    // clock ordering against the last good time
    assign w_clk_good = !r_lost && (i_obs.now_ms >= r_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_lost <= 1'b0;
        end else if (i_accept) begin
            if (w_clk_good) begin
                r_last <= i_obs.now_ms;
            end else begin
                r_lost <= 1'b1;
            end
        end
    end

    // field checks
    assign w_bad_key = (i_obs.org_key == '0) || (i_obs.site_key == '0)
                    || (i_obs.network_low == '0);
    assign w_bad_proxy = (i_obs.proxy_node == '0) || (i_obs.proxy_node == '1)
                    || (i_obs.radio_channel == '0)
                    || (i_obs.radio_channel > jcand_pkg::CHANNEL_MAX)
                    || (i_obs.relay_mac == '0)
                    || ((i_obs.relay_mac[47:40] & jcand_pkg::GROUP_BIT) != '0);

    assign o_job.obs = i_obs;
    assign o_job.rej = !w_clk_good || w_bad_key || w_bad_proxy;
    assign o_lost    = r_lost;

endmodule

>>> rtl/core/jcand_queue.sv
// two-entry queue between front and back
module jcand_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jcand_pkg::t_job   i_job,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output jcand_pkg::t_job   o_job
);

    jcand_pkg::t_job r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == 2'd2;
    assign o_job   = r_mem[r_rp];

endmodule

>>> rtl/core/jcand_back.sv
// back end: record scan, insert or evict, slot refresh and result register
module jcand_back #(
    parameter int RECORDS            = 8,
    parameter int PROXIES_PER_RECORD = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_fresh,
    input  logic              i_q_valid,
    input  jcand_pkg::t_job   i_q_job,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output jcand_pkg::t_res   o_out_word
);

    localparam int SN = RECORDS * PROXIES_PER_RECORD;
    localparam int RW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int KW = (PROXIES_PER_RECORD > 1) ? $clog2(PROXIES_PER_RECORD) : 1;
    localparam int SW = (SN > 1) ? $clog2(SN) : 1;

    // record store
    logic [RECORDS-1:0] r_used;
    logic [31:0]        r_rec_org  [RECORDS];
    logic [31:0]        r_rec_site [RECORDS];
    logic [31:0]        r_rec_net  [RECORDS];
    logic [63:0]        r_rec_seen [RECORDS];

    // slot store
    logic [SN-1:0]      r_present;
    logic [47:0]        r_s_mac   [SN];
    logic [63:0]        r_s_node  [SN];
    logic [3:0]         r_s_chan  [SN];
    logic signed [7:0]  r_s_str   [SN];
    logic [7:0]         r_s_hops  [SN];
    logic [1:0]         r_s_flags [SN];
    logic [63:0]        r_s_seen  [SN];

    // sequencer state
    jcand_pkg::t_state r_state, n_state;
    jcand_pkg::t_obs   r_job, n_job;
    logic [RW-1:0]     r_idx, n_idx;
    logic [RW-1:0]     r_rec, n_rec;
    logic [1:0]        r_code, n_code;
    logic              r_free_v, n_free_v;
    logic [RW-1:0]     r_free_idx, n_free_idx;
    logic [RW-1:0]     r_old_idx, n_old_idx;
    logic [63:0]       r_old_time, n_old_time;
    logic [KW-1:0]     r_k, n_k;
    logic              r_sv, n_sv;
    logic [KW-1:0]     r_sidx, n_sidx;
    logic [63:0]       r_stime, n_stime;
    logic [7:0]        r_shops, n_shops;
    logic signed [7:0] r_sstr, n_sstr;
    logic [47:0]       r_smac, n_smac;
    logic              r_wv, n_wv;
    logic [KW-1:0]     r_widx, n_widx;
    logic [7:0]        r_whops, n_whops;
    logic signed [7:0] r_wstr, n_wstr;
    logic [47:0]       r_wmac, n_wmac;
    logic              r_oval, n_oval;
    jcand_pkg::t_res   r_out, n_out;

    logic              w_hit;
    logic [SW-1:0]     w_ridx;
    logic [SW-1:0]     w_widx_s;
    logic [KW-1:0]     w_wk;
    logic              w_slot_we;
    logic              w_fresh;
    logic              w_stale_take;
    logic              w_worst_take;

    // record compare at scan index
    assign w_hit = r_used[r_idx]
                && (r_rec_org[r_idx] == r_job.org_key)
                && (r_rec_site[r_idx] == r_job.site_key)
                && (r_rec_net[r_idx] == r_job.network_low);

    // slot addresses
    assign w_ridx   = SW'(int'(r_rec) * PROXIES_PER_RECORD + int'(r_k));
    assign w_widx_s = SW'(int'(r_rec) * PROXIES_PER_RECORD + int'(w_wk));

    // slot classification at the current slot
    assign w_fresh = (r_job.now_ms - r_s_seen[w_ridx]) <= {32'd0, i_fresh};
    assign w_stale_take = !w_fresh && (!r_sv || (r_s_seen[w_ridx] < r_stime)
        || ((r_s_seen[w_ridx] == r_stime)
            && jcand_pkg::ranks_better(r_shops, r_sstr, r_smac, r_s_hops[w_ridx],
                                       r_s_str[w_ridx], r_s_mac[w_ridx])));
    assign w_worst_take = !r_wv
        || jcand_pkg::ranks_better(r_whops, r_wstr, r_wmac, r_s_hops[w_ridx],
                                   r_s_str[w_ridx], r_s_mac[w_ridx]);

    // next state and outputs
    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_idx      = r_idx;
        n_rec      = r_rec;
        n_code     = r_code;
        n_free_v   = r_free_v;
        n_free_idx = r_free_idx;
        n_old_idx  = r_old_idx;
        n_old_time = r_old_time;
        n_k        = r_k;
        n_sv       = r_sv;
        n_sidx     = r_sidx;
        n_stime    = r_stime;
        n_shops    = r_shops;
        n_sstr     = r_sstr;
        n_smac     = r_smac;
        n_wv       = r_wv;
        n_widx     = r_widx;
        n_whops    = r_whops;
        n_wstr     = r_wstr;
        n_wmac     = r_wmac;
        n_oval     = r_oval && i_out_stall;
        n_out      = r_out;
        o_q_pop    = 1'b0;
        w_slot_we  = 1'b0;
        w_wk       = r_k;
        case (r_state)
            jcand_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_job    = i_q_job.obs;
                    n_idx    = '0;
                    n_free_v = 1'b0;
                    if (i_q_job.rej) begin
                        n_code  = jcand_pkg::OUTC_REJECTED;
                        n_rec   = '0;
                        n_state = jcand_pkg::ST_EMIT;
                    end else begin
                        n_state = jcand_pkg::ST_SCAN;
                    end
                end
            end
            jcand_pkg::ST_SCAN: begin
                n_k  = '0;
                n_sv = 1'b0;
                n_wv = 1'b0;
                if (w_hit) begin
                    n_rec   = r_idx;
                    n_code  = jcand_pkg::OUTC_UPDATED;
                    n_state = jcand_pkg::ST_SLOT;
                end else begin
                    if (!r_used[r_idx] && !r_free_v) begin
                        n_free_v   = 1'b1;
                        n_free_idx = r_idx;
                    end
                    if ((r_idx == '0) || (r_rec_seen[r_idx] < r_old_time)) begin
                        n_old_idx  = r_idx;
                        n_old_time = r_rec_seen[r_idx];
                    end
                    if (int'(r_idx) == RECORDS - 1) begin
                        n_state = jcand_pkg::ST_INSERT;
                        if (n_free_v) begin
                            n_rec  = n_free_idx;
                            n_code = jcand_pkg::OUTC_INSERTED;
                        end else begin
                            n_rec  = n_old_idx;
                            n_code = jcand_pkg::OUTC_EVICTED;
                        end
                    end else begin
                        n_idx = r_idx + RW'(1);
                    end
                end
            end
            jcand_pkg::ST_INSERT: begin
                // fresh record: proxy goes to its first slot
                w_wk      = '0;
                w_slot_we = 1'b1;
                n_state   = jcand_pkg::ST_EMIT;
            end
            jcand_pkg::ST_SLOT: begin
                if (!r_present[w_ridx] || (r_s_mac[w_ridx] == r_job.relay_mac)) begin
                    w_slot_we = 1'b1;
                    n_state   = jcand_pkg::ST_EMIT;
                end else begin
                    if (w_stale_take) begin
                        n_sv    = 1'b1;
                        n_sidx  = r_k;
                        n_stime = r_s_seen[w_ridx];
                        n_shops = r_s_hops[w_ridx];
                        n_sstr  = r_s_str[w_ridx];
                        n_smac  = r_s_mac[w_ridx];
                    end
                    if (w_worst_take) begin
                        n_wv    = 1'b1;
                        n_widx  = r_k;
                        n_whops = r_s_hops[w_ridx];
                        n_wstr  = r_s_str[w_ridx];
                        n_wmac  = r_s_mac[w_ridx];
                    end
                    if (int'(r_k) == PROXIES_PER_RECORD - 1) begin
                        n_state = jcand_pkg::ST_FINAL;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end
            end
            jcand_pkg::ST_FINAL: begin
                // stale slot first, else replace the worst if outranked
                if (r_sv) begin
                    w_wk      = r_sidx;
                    w_slot_we = 1'b1;
                end else begin
                    w_wk      = r_widx;
                    w_slot_we = r_wv && jcand_pkg::ranks_better(r_job.hop_count,
                        r_job.signal_strength, r_job.relay_mac, r_whops, r_wstr, r_wmac);
                end
                n_state = jcand_pkg::ST_EMIT;
            end
            jcand_pkg::ST_EMIT: begin
                if (!r_oval || !i_out_stall) begin
                    n_oval            = 1'b1;
                    n_out.outcome     = r_code;
                    n_out.record_slot = 3'(r_rec);
                    n_state           = jcand_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jcand_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jcand_pkg::ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_idx      <= n_idx;
        r_rec      <= n_rec;
        r_code     <= n_code;
        r_free_v   <= n_free_v;
        r_free_idx <= n_free_idx;
        r_old_idx  <= n_old_idx;
        r_old_time <= n_old_time;
        r_k        <= n_k;
        r_sv       <= n_sv;
        r_sidx     <= n_sidx;
        r_stime    <= n_stime;
        r_shops    <= n_shops;
        r_sstr     <= n_sstr;
        r_smac     <= n_smac;
        r_wv       <= n_wv;
        r_widx     <= n_widx;
        r_whops    <= n_whops;
        r_wstr     <= n_wstr;
        r_wmac     <= n_wmac;
        r_out      <= n_out;
    end

    // used and present bits; an inserted record keeps only its first slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_present <= '0;
        end else begin
            if (r_state == jcand_pkg::ST_INSERT) begin
                r_used[r_rec] <= 1'b1;
                for (int k = 0; k < PROXIES_PER_RECORD; k++) begin
                    r_present[SW'(int'(r_rec) * PROXIES_PER_RECORD + k)] <= (k == 0);
                end
            end else if (w_slot_we) begin
                r_present[w_widx_s] <= 1'b1;
            end
        end
    end

    // record payload
    always_ff @(posedge i_clk) begin
        if (r_state == jcand_pkg::ST_INSERT) begin
            r_rec_org[r_rec]  <= r_job.org_key;
            r_rec_site[r_rec] <= r_job.site_key;
            r_rec_net[r_rec]  <= r_job.network_low;
            r_rec_seen[r_rec] <= r_job.now_ms;
        end else if ((r_state == jcand_pkg::ST_SCAN) && w_hit) begin
            r_rec_seen[r_idx] <= r_job.now_ms;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_s_mac[w_widx_s]   <= r_job.relay_mac;
            r_s_node[w_widx_s]  <= r_job.proxy_node;
            r_s_chan[w_widx_s]  <= r_job.radio_channel[3:0];
            r_s_str[w_widx_s]   <= r_job.signal_strength;
            r_s_hops[w_widx_s]  <= r_job.hop_count;
            r_s_flags[w_widx_s] <= {r_job.proxy_loaded, r_job.authority_ok};
            r_s_seen[w_widx_s]  <= r_job.now_ms;
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_word  = r_out;

endmodule

>>> rtl/core/join_candidate_table_upsert.sv
// top level of the join candidate table upsert block
//
//  channel  | signals                                  | direction
//  in       | i_in_valid, o_in_stall, i_in_word        | observation word in
//  out      | o_out_valid, i_out_stall, o_out_word     | outcome word out
//  cfg      | i_cfg_we, i_cfg_wdata                    | fresh window write
//
// rejected words skip the walks and go from the idle state to the emit state;
// inserts walk all RECORDS, one per cycle; updates stop the walk at the hit,
// then walk up to PROXIES_PER_RECORD slots; the back end sequencer runs the walks.
// a two-entry queue lets the front keep taking words while the back is busy.
// reset is synchronous: table empty, clock state cleared, window 30000 ms.
// a stalled result holds in the output register; the sequencer waits on it.
module join_candidate_table_upsert #(
    parameter int RECORDS            = 8,
    parameter int PROXIES_PER_RECORD = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  jcand_pkg::t_obs   i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output jcand_pkg::t_res   o_out_word,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata
);

    logic [31:0]     r_fresh;
    logic            w_accept;
    logic            w_full;
    logic            w_q_valid;
    logic            w_pop;
    logic            w_lost;
    jcand_pkg::t_job w_push_job;
    jcand_pkg::t_job w_q_job;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= jcand_pkg::FRESH_DEFAULT;
        end else if (i_cfg_we) begin
            r_fresh <= i_cfg_wdata;
        end
    end

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    // front end
    jcand_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_obs    (i_in_word),
        .o_job    (w_push_job),
        .o_lost   (w_lost)
    );

    // queue
    jcand_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_job   (w_q_job)
    );

    // back end
    jcand_back #(
        .RECORDS            (RECORDS),
        .PROXIES_PER_RECORD (PROXIES_PER_RECORD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fresh     (r_fresh),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // lost clock stays lost until reset
    a_lost_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lost |=> w_lost)
        else $error("clock lost flag dropped");

    // rejected results name record zero
    a_reject_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.outcome == jcand_pkg::OUTC_REJECTED))
        |-> (o_out_word.record_slot == 3'd0))
        else $error("rejected result with nonzero record");

    // queue never pops when empty
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

endmodule

>>> tb/testbench.sv
// self-checking testbench for the join candidate table upsert block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREC = 8;
    localparam int NPX = 2;
    localparam int NSL = NREC * NPX;
    localparam int N_RANDOM = 1150;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_stall;
    jcand_pkg::t_obs i_in_word;
    logic    o_out_valid;
    logic    i_out_stall;
    jcand_pkg::t_res o_out_word;
    logic    i_cfg_we;
    logic [31:0] i_cfg_wdata;

    join_candidate_table_upsert #(.RECORDS(NREC), .PROXIES_PER_RECORD(NPX)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // shadow table state
    logic [31:0] win_ms;
    logic        rec_used [NREC];
    logic [31:0] rec_org [NREC];
    logic [31:0] rec_site [NREC];
    logic [31:0] rec_net [NREC];
    logic [63:0] rec_seen [NREC];
    logic        px_present [NSL];
    logic [47:0] px_mac [NSL];
    logic signed [7:0] px_rssi [NSL];
    logic [7:0]  px_hops [NSL];
    logic [63:0] px_seen [NSL];
    logic [63:0] prev_time;
    logic        time_broken;

    jcand_pkg::t_res outcome_queue[$];
    int   fail_count = 0;
    int   word_count = 0;
    int   reject_count = 0;
    int   evict_count = 0;
    bit   idle_on = 1;

    function automatic bit slot_ahead(int a, int b);
        return jcand_pkg::ranks_better(px_hops[a], px_rssi[a], px_mac[a],
                                       px_hops[b], px_rssi[b], px_mac[b]);
    endfunction

    function automatic void store_proxy(int s, jcand_pkg::t_obs w);
        px_present[s] = 1;
        px_mac[s] = w.relay_mac;
        px_rssi[s] = w.signal_strength;
        px_hops[s] = w.hop_count;
        px_seen[s] = w.now_ms;
    endfunction

    // pick the slot of record r for this proxy
    function automatic void refresh_proxy(int r, jcand_pkg::t_obs w);
        int stale;
        int worst;
        int s;
        logic [63:0] age;
        stale = -1;
        worst = -1;
        for (int k = 0; k < NPX; k++) begin
            s = r * NPX + k;
            if (!px_present[s] || px_mac[s] == w.relay_mac) begin
                store_proxy(s, w);
                return;
            end
            age = w.now_ms - px_seen[s];
            if (age > {32'd0, win_ms} &&
                (stale < 0 || px_seen[s] < px_seen[stale] ||
                 (px_seen[s] == px_seen[stale] && slot_ahead(stale, s))))
                stale = s;
            if (worst < 0 || slot_ahead(worst, s))
                worst = s;
        end
        if (stale >= 0)
            store_proxy(stale, w);
        else if (worst >= 0 && jcand_pkg::ranks_better(w.hop_count, w.signal_strength,
                 w.relay_mac, px_hops[worst], px_rssi[worst], px_mac[worst]))
            store_proxy(worst, w);
    endfunction

    function automatic jcand_pkg::t_res predict_upsert(jcand_pkg::t_obs w);
        jcand_pkg::t_res res;
        bit   good;
        int   first;
        int   pick;
        good = 1;
        first = -1;
        pick = -1;
        if (time_broken) begin
            good = 0;
        end else if (w.now_ms < prev_time) begin
            time_broken = 1;
            good = 0;
        end else begin
            prev_time = w.now_ms;
        end
        if (!good || w.org_key == 0 || w.site_key == 0 || w.network_low == 0 ||
            w.proxy_node == 0 || w.proxy_node == '1 || w.radio_channel == 0 ||
            w.radio_channel > jcand_pkg::CHANNEL_MAX || w.relay_mac == 0 ||
            (w.relay_mac[47:40] & jcand_pkg::GROUP_BIT) != 0) begin
            res.outcome = jcand_pkg::OUTC_REJECTED;
            res.record_slot = '0;
            return res;
        end
        for (int r = 0; r < NREC; r++) begin
            if (rec_used[r] && rec_org[r] == w.org_key && rec_site[r] == w.site_key &&
                rec_net[r] == w.network_low) begin
                refresh_proxy(r, w);
                rec_seen[r] = w.now_ms;
                if (first < 0) first = r;
            end
        end
        if (first >= 0) begin
            res.outcome = jcand_pkg::OUTC_UPDATED;
            res.record_slot = first[2:0];
            return res;
        end
        res.outcome = jcand_pkg::OUTC_INSERTED;
        for (int r = 0; r < NREC; r++) begin
            if (!rec_used[r]) begin
                pick = r;
                break;
            end
        end
        if (pick < 0) begin
            for (int r = 0; r < NREC; r++)
                if (pick < 0 || rec_seen[r] < rec_seen[pick]) pick = r;
            res.outcome = jcand_pkg::OUTC_EVICTED;
        end
        for (int k = 0; k < NPX; k++) px_present[pick * NPX + k] = 0;
        rec_used[pick] = 1;
        rec_org[pick] = w.org_key;
        rec_site[pick] = w.site_key;
        rec_net[pick] = w.network_low;
        rec_seen[pick] = w.now_ms;
        refresh_proxy(pick, w);
        res.record_slot = pick[2:0];
        return res;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stall
    initial begin
        i_out_stall = 0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= idle_on && ($urandom_range(99) < 10);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        jcand_pkg::t_res exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcome_queue.size() == 0) begin
                $error("result with nothing expected: outcome %0d slot %0d",
                       o_out_word.outcome, o_out_word.record_slot);
                fail_count++;
            end else begin
                exp_res = outcome_queue.pop_front();
                if (o_out_word.outcome !== exp_res.outcome) begin
                    $error("outcome expected %0d actual %0d",
                           exp_res.outcome, o_out_word.outcome);
                    fail_count++;
                end
                if (o_out_word.record_slot !== exp_res.record_slot) begin
                    $error("record_slot expected %0d actual %0d",
                           exp_res.record_slot, o_out_word.record_slot);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on handshake activity
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL join_candidate_table_upsert");
                $finish;
            end
        end
    end

    // send one word, checked against the predictor or a typed expectation
    task automatic send_word(jcand_pkg::t_obs w, bit fixed, jcand_pkg::t_res fixed_res);
        jcand_pkg::t_res pred;
        while (idle_on && $urandom_range(99) < 10) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_upsert(w);
        if (fixed && pred != fixed_res) begin
            $error("table row disagrees with predictor: outcome %0d slot %0d",
                   fixed_res.outcome, fixed_res.record_slot);
            fail_count++;
        end
        outcome_queue.push_back(pred);
        word_count++;
        if (pred.outcome == jcand_pkg::OUTC_REJECTED) reject_count++;
        if (pred.outcome == jcand_pkg::OUTC_EVICTED) evict_count++;
    endtask

    // stop sending and wait for every expected result
    task automatic drain_all();
        i_in_valid <= 0;
        while (outcome_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(logic [31:0] v);
        drain_all();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        win_ms = v;
    endtask

    function automatic jcand_pkg::t_obs good_word(int key, logic [63:0] t);
        jcand_pkg::t_obs w;
        w.org_key = 32'h100 + key;
        w.site_key = 32'h200 + key;
        w.network_low = 32'h300 + key;
        w.relay_mac = 48'({$urandom, $urandom}) & 48'hFEFF_FFFF_FFFF;
        if (w.relay_mac == 0) w.relay_mac = 48'h2;
        w.proxy_node = {$urandom, $urandom} | 64'h1;
        if (w.proxy_node == '1) w.proxy_node = 64'h5;
        w.radio_channel = 8'($urandom_range(14, 1));
        w.signal_strength = 8'($urandom);
        w.hop_count = $urandom_range(3) == 0 ? 8'd255 : 8'($urandom_range(8));
        w.authority_ok = 1'($urandom);
        w.proxy_loaded = 1'($urandom);
        w.now_ms = t;
        return w;
    endfunction

    // directed rows
    typedef struct {
        int          key;
        logic [63:0] dt;
        int          tweak;
        bit          fixed;
        logic [1:0]  outc;
        logic [2:0]  slot;
    } t_row;

    localparam int TW_NONE = 0, TW_ORG0 = 1, TW_SITE0 = 2, TW_NET0 = 3, TW_MAC0 = 4,
        TW_GROUP = 5, TW_NODE0 = 6, TW_NODE1 = 7, TW_CH0 = 8, TW_CH15 = 9, TW_CHMAX = 10,
        TW_EXTREME = 11, TW_SAMEMAC = 12, TW_BACK = 13;

    t_row rows [] = '{
        '{0, 0, TW_ORG0, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 0, TW_SITE0, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 0, TW_NET0, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 0, TW_MAC0, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 0, TW_GROUP, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 0, TW_NODE0, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 0, TW_NODE1, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 0, TW_CH0, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 0, TW_CH15, 1, jcand_pkg::OUTC_REJECTED, 0},
        '{0, 10, TW_NONE, 1, jcand_pkg::OUTC_INSERTED, 0},
        '{0, 10, TW_SAMEMAC, 1, jcand_pkg::OUTC_UPDATED, 0},
        '{0, 10, TW_EXTREME, 1, jcand_pkg::OUTC_UPDATED, 0},
        '{0, 10, TW_CHMAX, 1, jcand_pkg::OUTC_UPDATED, 0},
        '{1, 10, TW_NONE, 1, jcand_pkg::OUTC_INSERTED, 1},
        '{2, 10, TW_NONE, 1, jcand_pkg::OUTC_INSERTED, 2},
        '{3, 10, TW_NONE, 1, jcand_pkg::OUTC_INSERTED, 3},
        '{4, 10, TW_NONE, 1, jcand_pkg::OUTC_INSERTED, 4},
        '{5, 10, TW_NONE, 1, jcand_pkg::OUTC_INSERTED, 5},
        '{6, 10, TW_NONE, 1, jcand_pkg::OUTC_INSERTED, 6},
        '{7, 10, TW_NONE, 1, jcand_pkg::OUTC_INSERTED, 7},
        '{8, 10, TW_NONE, 1, jcand_pkg::OUTC_EVICTED, 0},
        '{1, 40000, TW_NONE, 0, 0, 0},
        '{1, 1, TW_NONE, 0, 0, 0}
    };

    // stimulus
    initial begin
        jcand_pkg::t_obs w;
        jcand_pkg::t_res none;
        logic [63:0] clock_now;
        logic [31:0] windows [5] = '{32'd0, 32'd50, 32'd30000, 32'd400, 32'hFFFF_FFFF};
        none = '0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        win_ms = jcand_pkg::FRESH_DEFAULT;
        for (int r = 0; r < NREC; r++) rec_used[r] = 0;
        for (int s = 0; s < NSL; s++) px_present[s] = 0;
        prev_time = 0;
        time_broken = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed walk at the reset window
        clock_now = 0;
        foreach (rows[i]) begin
            clock_now += rows[i].dt;
            w = good_word(rows[i].key, clock_now);
            case (rows[i].tweak)
                TW_ORG0:    w.org_key = '0;
                TW_SITE0:   w.site_key = '0;
                TW_NET0:    w.network_low = '0;
                TW_MAC0:    w.relay_mac = '0;
                TW_GROUP:   w.relay_mac = 48'h0100_0000_0001;
                TW_NODE0:   w.proxy_node = '0;
                TW_NODE1:   w.proxy_node = '1;
                TW_CH0:     w.radio_channel = '0;
                TW_CH15:    w.radio_channel = 8'd15;
                TW_CHMAX:   w.radio_channel = jcand_pkg::CHANNEL_MAX;
                TW_EXTREME: begin
                    w.org_key = 32'h100; w.relay_mac = 48'hFEFF_FFFF_FFFF;
                    w.proxy_node = 64'hFFFF_FFFF_FFFF_FFFE; w.signal_strength = 8'sh80;
                    w.hop_count = 8'd0;
                end
                TW_SAMEMAC: w.signal_strength = 8'sd127;
                default: ;
            endcase
            send_word(w, rows[i].fixed, rows[i].fixed ?
                      jcand_pkg::t_res'{rows[i].outc, rows[i].slot} : none);
        end

        // random phases at several windows; the clock runs up, but one word of the last phase is sent at time zero
        for (int p = 0; p < 5; p++) begin
            write_window(windows[p]);
            idle_on = (p != 2);
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                clock_now += $urandom_range(3) == 0 ? 0 : $urandom_range(600);
                w = good_word($urandom_range(11), clock_now);
                if ($urandom_range(3) == 0) w.relay_mac = {8'($urandom_range(3)), 40'h2};
                if ($urandom_range(15) == 0) begin
                    w = jcand_pkg::t_obs'({$urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                    w.now_ms = clock_now;
                end
                if (p == 4 && n == 200) w.now_ms = '0;
                send_word(w, 0, none);
                if (n == 100) drain_all();
            end
        end
        // the clock already ran backwards, so even words at the latest time are rejected for good
        w = good_word(0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(w, 0, none);
        w = good_word(0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(w, 0, none);

        drain_all();
        $display("covered %0d words, %0d rejected, %0d evictions, five fresh windows",
                 word_count, reject_count, evict_count);
        if (fail_count == 0)
            $display("PASS join_candidate_table_upsert");
        else
            $display("FAIL join_candidate_table_upsert");
        $finish;
    end
endmodule

>>> join_candidate_table_upsert.f
rtl/core/jcand_pkg.sv
rtl/core/jcand_front.sv
rtl/core/jcand_queue.sv
rtl/core/jcand_back.sv
rtl/core/join_candidate_table_upsert.sv
tb/testbench.sv
